// File: hdl/pcxd_pkg.sv
// Shared types, codes and constants for the PCX run-length scanline decoder.
`timescale 1ns / 1ps
`default_nettype none
package pcxd_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int OFFSET_W        = 18;
  localparam int RUN_W           = 6;

  // A byte at or above this value opens a run; its low bits are the count.
  localparam logic [7:0]  RUN_MARK = 8'd192;

  localparam logic [15:0] LINE_LENGTH_RST  = 16'd1;
  localparam logic [15:0] PAD_LENGTH_RST   = 16'd0;
  localparam logic [2:0]  PIXEL_STRIDE_RST = 3'd1;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_TRUNC   = 2'd1,
    ERR_OVERRUN = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    REG_LINE_LENGTH  = 2'd0,
    REG_PAD_LENGTH   = 2'd1,
    REG_PIXEL_STRIDE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_data;
  } code_t;

  typedef struct packed {
    logic                pixel_valid;
    logic [7:0]          pixel_value;
    logic [OFFSET_W-1:0] dest_offset;
    logic                line_done;
    err_t                error_code;
    logic                last;
  } pix_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic calc;
    logic emit_pixel;
    logic emit_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_header;
    logic kept_zero;
    logic fin;
    logic cnt_one;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: hdl/pcxd_chan_if.sv
// Valid/ready channel interface carrying one payload word.
`timescale 1ns / 1ps
`default_nettype none
interface pcxd_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/pcxd_ctrl.sv
// Controller state machine: sequences accept, compute, pixel emit and status emit.
`timescale 1ns / 1ps
`default_nettype none
module pcxd_ctrl
  import pcxd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          // a run header only arms the next byte
          if (!sts.is_header) state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        if (!sts.kept_zero)  state_next = ST_EMIT;
        else if (sts.fin)    state_next = ST_STATUS;
        else                 state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_pixel = 1'b1;
          if (sts.cnt_one) state_next = ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/pcxd_dp.sv
// Datapath: config registers, line counters, run decode and output register.
`timescale 1ns / 1ps
`default_nettype none
module pcxd_dp
  import pcxd_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_valid,
  input  cfg_t  cfg_data,
  input  code_t in_data,
  input  cmd_t  cmd,
  output sts_t  sts,
  output logic  out_valid,
  input  logic  out_ready,
  output pix_t  out_data
);

  localparam int CW = COUNT_WIDTH;

  logic [15:0]         line_length;
  logic [15:0]         pad_length;
  logic [2:0]          pixel_stride;

  logic                awaiting;
  logic [RUN_W-1:0]    pending;
  logic [CW-1:0]       keep_rem;
  logic [CW-1:0]       skip_rem;
  logic [OFFSET_W-1:0] offset;

  logic [RUN_W-1:0]    cnt;       // count of the item in flight
  logic [7:0]          value;
  logic                eod;
  logic [RUN_W-1:0]    emit_cnt;  // kept bytes still to send
  logic                fin_done;
  err_t                fin_err;

  logic [CW-1:0]       keep_load;
  logic [CW-1:0]       skip_load;
  logic [RUN_W-1:0]    kept_c;
  logic [RUN_W-1:0]    spill_c;
  logic                err_c;
  logic [CW-1:0]       keep_new;
  logic [CW-1:0]       skip_new;
  logic                done_c;
  logic                fin_c;
  logic                out_load;

  // Reload values; a zero line length keeps one byte.
  always_comb begin
    keep_load = CW'(line_length);
    if (keep_load == '0) keep_load = CW'(1);
    skip_load = CW'(pad_length);
  end

  // Split of the count into kept part and the part that lands in the pad.
  always_comb begin
    if (keep_rem == '0)                 kept_c = '0;
    else if (CW'(cnt) < keep_rem)       kept_c = cnt;
    else                                kept_c = RUN_W'(keep_rem);
    spill_c  = cnt - kept_c;
    err_c    = CW'(spill_c) > skip_rem;
    keep_new = keep_rem - CW'(kept_c);
    skip_new = skip_rem - CW'(spill_c);
    done_c   = !err_c && (keep_new == '0) && (skip_new == '0);
    fin_c    = eod || err_c || done_c;
  end

  assign sts.is_header = !in_data.end_of_data && !awaiting && (in_data.code_byte >= RUN_MARK);
  assign sts.kept_zero = eod || (kept_c == '0);
  assign sts.fin       = fin_c;
  assign sts.cnt_one   = (emit_cnt == RUN_W'(1));
  assign sts.out_free  = !out_valid || out_ready;

  assign out_load = cmd.emit_pixel || cmd.emit_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= LINE_LENGTH_RST;
      pad_length   <= PAD_LENGTH_RST;
      pixel_stride <= PIXEL_STRIDE_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_data.index))
        REG_LINE_LENGTH:  line_length  <= cfg_data.data;
        REG_PAD_LENGTH:   pad_length   <= cfg_data.data;
        REG_PIXEL_STRIDE: pixel_stride <= cfg_data.data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting  <= 1'b0;
      pending   <= '0;
      keep_rem  <= CW'(LINE_LENGTH_RST);
      skip_rem  <= CW'(PAD_LENGTH_RST);
      offset    <= '0;
      out_valid <= 1'b0;
      emit_cnt  <= '0;
    end else begin
      if (cmd.accept) begin
        if (in_data.end_of_data) begin
          awaiting <= 1'b0;
          pending  <= '0;
        end else if (sts.is_header) begin
          awaiting <= 1'b1;
          pending  <= in_data.code_byte[RUN_W-1:0];
        end else begin
          awaiting <= 1'b0;
          pending  <= '0;
        end
      end
      if (cmd.calc) begin
        emit_cnt <= eod ? '0 : kept_c;
        if (fin_c) begin
          keep_rem <= keep_load;
          skip_rem <= skip_load;
        end else begin
          keep_rem <= keep_new;
          skip_rem <= skip_new;
        end
      end
      if (cmd.emit_pixel) begin
        emit_cnt <= emit_cnt - RUN_W'(1);
        if (sts.cnt_one && (fin_done || fin_err != ERR_NONE)) begin
          offset <= '0;
        end else begin
          offset <= offset + OFFSET_W'(pixel_stride);
        end
      end
      if (cmd.emit_status) offset <= '0;
      if (out_load)        out_valid <= 1'b1;
      else if (out_ready)  out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      eod   <= in_data.end_of_data;
      value <= in_data.code_byte;
      cnt   <= awaiting ? pending : RUN_W'(1);
    end
    if (cmd.calc) begin
      fin_done <= !eod && done_c;
      if (eod)        fin_err <= ERR_TRUNC;
      else if (err_c) fin_err <= ERR_OVERRUN;
      else            fin_err <= ERR_NONE;
    end
    if (cmd.emit_pixel) begin
      out_data.pixel_valid <= 1'b1;
      out_data.pixel_value <= value;
      out_data.dest_offset <= offset;
      out_data.line_done   <= sts.cnt_one && fin_done;
      out_data.error_code  <= sts.cnt_one ? fin_err : ERR_NONE;
      out_data.last        <= sts.cnt_one;
    end else if (cmd.emit_status) begin
      out_data.pixel_valid <= 1'b0;
      out_data.pixel_value <= '0;
      out_data.dest_offset <= '0;
      out_data.line_done   <= fin_done;
      out_data.error_code  <= fin_err;
      out_data.last        <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: hdl/pcx_rle_scanline_decoder.sv
// Top level of the PCX run-length scanline decoder.
// A literal is accepted in ST_IDLE and decoded in ST_CALC, and a kept pixel is loaded in ST_EMIT;
// a run header is only accepted. A run value byte sends its kept pixel words, one pixel word per cycle
//   from the shared output register while the sink is ready.
// Status-only words (line done, truncated, run overflow) are loaded in ST_STATUS after ST_CALC.
// Reset (rst, synchronous, active high) loads register defaults and clears line state.
`timescale 1ns / 1ps
`default_nettype none
module pcx_rle_scanline_decoder
  import pcxd_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pcxd_chan_if.sink   cfg,    // register writes, always ready
  pcxd_chan_if.sink   code,   // compressed byte words
  pcxd_chan_if.source pixel   // decoded pixel and status words
);

  cmd_t cmd;
  sts_t sts;

  // Config writes are registered directly, so the port never stalls.
  assign cfg.ready = 1'b1;

  // Controller owns only the input handshake and sequencing.
  pcxd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (code.valid),
    .in_ready (code.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath holds counters, the decoded byte and the output register.
  pcxd_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .in_data   (code.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready),
    .out_data  (pixel.data)
  );

endmodule
`default_nettype wire

// File: hdl/pcxd_checker.sv
// Port-level checks for the decoder output stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pcxd_checker
  import pcxd_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input pix_t out_data
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("pixel word changed while stalled");

  // status-only word closes its item and is blank
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.pixel_valid |->
      out_data.last && out_data.pixel_value == 8'd0 && out_data.dest_offset == '0)
    else $error("status word not last or not blank");

  // flags ride only on the final word of an item
  a_flag_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.line_done || out_data.error_code != ERR_NONE) |-> out_data.last)
    else $error("line flag on non-final word");

  // completion and error exclude each other
  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.line_done |-> out_data.error_code == ERR_NONE)
    else $error("line done with error");

endmodule

bind pcx_rle_scanline_decoder pcxd_checker u_pcxd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (pixel.valid),
  .out_ready (pixel.ready),
  .out_data  (pixel.data)
);
`default_nettype wire
